>>> rtl/core/dqo_pkg.sv
// shared constants, types and helpers for the dithered quadrature oscillator
package dqo_pkg;

    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PHASE_W   = 31;
    localparam int MASK_W    = 16;
    localparam int CMD_W     = 2;
    localparam int CFG_IDX_W = 2;
    localparam int MUL_CNT_W = $clog2(PHASE_W);

    localparam logic [PHASE_W-1:0] PHASE_RESET = PHASE_W'(411775);
    localparam logic [DATA_W-1:0]  SEED_RESET  = DATA_W'(1337);
    localparam logic [DATA_W-1:0]  COS_ONE     = DATA_W'(1) << FRAC_BITS;

    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP  = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_DITHER_MASK = CFG_IDX_W'(1);

    typedef enum logic [CMD_W-1:0] {
        CMD_STEP    = 2'd0,
        CMD_RESTART = 2'd1,
        CMD_CLEAR   = 2'd2,
        CMD_LOAD    = 2'd3
    } cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_stat_t;

    // xorshift32 with shifts 13, 17, 5
    function automatic logic [DATA_W-1:0] xorshift(input logic [DATA_W-1:0] seed);
        logic [DATA_W-1:0] r;
        r = seed;
        r = r ^ (r << 13);
        r = r ^ (r >> 17);
        r = r ^ (r << 5);
        return r;
    endfunction

endpackage

>>> rtl/core/dqo_mul.sv
// bit-serial shift-add multiplier: signed value times unsigned phase step, scaled
module dqo_mul (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    input  logic signed [dqo_pkg::DATA_W-1:0] multiplicand,
    input  logic [dqo_pkg::PHASE_W-1:0]     multiplier,
    output dqo_pkg::mul_stat_t              stat,
    output logic [dqo_pkg::DATA_W-1:0]      product
);
    import dqo_pkg::*;

    localparam logic [MUL_CNT_W-1:0] MUL_LAST = MUL_CNT_W'(PHASE_W - 1);

    logic signed [DATA_W:0]    acc_reg;
    logic [PHASE_W-1:0]        low_reg;
    logic signed [DATA_W:0]    mcand_reg;
    logic [PHASE_W-1:0]        mplier_reg;
    logic [MUL_CNT_W-1:0]      cnt_reg;
    logic                      run_reg;
    logic                      done_reg;
    logic signed [DATA_W:0]    sum;
    logic [DATA_W+PHASE_W:0]   full;

    // acc stays within one multiplicand of zero, so 33 bits never overflow
    assign sum     = acc_reg + (mplier_reg[0] ? mcand_reg : '0);
    assign full    = {acc_reg, low_reg};
    assign product = full[FRAC_BITS+DATA_W-1:FRAC_BITS];
    assign stat.busy = run_reg;
    assign stat.done = done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            run_reg  <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (run_reg)
        begin
            cnt_reg <= cnt_reg + MUL_CNT_W'(1);
            if (cnt_reg == MUL_LAST)
            begin
                run_reg  <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg    <= '0;
            low_reg    <= '0;
            mcand_reg  <= {multiplicand[DATA_W-1], multiplicand};
            mplier_reg <= multiplier;
        end
        else if (run_reg)
        begin
            acc_reg    <= sum >>> 1;
            low_reg    <= {sum[0], low_reg[PHASE_W-1:1]};
            mplier_reg <= mplier_reg >> 1;
        end
    end

endmodule

>>> rtl/core/dithered_quadrature_oscillator_top.sv
// top level of the dithered quadrature oscillator
// Each input item carries a command (s_tuser) and a cosine value (s_tdata) and
// yields one result item holding sine, cosine, step count and crossing count
// after the command. Restart, clear and load go from acceptance through ST_OUT
// to the output register; a step runs the bit-serial multiplier twice (one
// phase_step bit per cycle), first for the sine update in ST_MUL_X, then for
// the cosine update in ST_MUL_Y, before ST_OUT. One item is in work at a time;
// a finished result waits in the output register while the next item is accepted.
module dithered_quadrature_oscillator_top (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dqo_pkg::DATA_W-1:0]       s_tdata,   // amplitude_value
    input  logic [dqo_pkg::CMD_W-1:0]        s_tuser,   // command
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // sine_out, cosine_out, step_total, crossing_total
    output logic [4*dqo_pkg::DATA_W-1:0]     m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [dqo_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [dqo_pkg::DATA_W-1:0]       cfg_data
);
    import dqo_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL_X,
        ST_MUL_Y,
        ST_OUT
    } state_t;

    state_t               state_reg;
    logic [PHASE_W-1:0]   phase_step_reg;
    logic [MASK_W-1:0]    dither_mask_reg;
    logic [DATA_W-1:0]    sine_reg;
    logic [DATA_W-1:0]    cosine_reg;
    logic [DATA_W-1:0]    seed_reg;
    logic                 prior_sign_reg;
    logic [DATA_W-1:0]    step_cnt_reg;
    logic [DATA_W-1:0]    cross_cnt_reg;
    logic [DATA_W-1:0]    dither_reg;
    logic                 m_tvalid_reg;
    logic [4*DATA_W-1:0]  m_tdata_reg;

    logic                 s_accept;
    cmd_t                 cmd;
    logic [DATA_W-1:0]    rng_next;
    logic [DATA_W-1:0]    sine_next;
    logic                 out_free;
    logic                 mul_start;
    logic [DATA_W-1:0]    mul_operand;
    mul_stat_t            mul_stat;
    logic [DATA_W-1:0]    mul_product;

    assign s_tready  = (state_reg == ST_IDLE);
    assign s_accept  = s_tvalid && s_tready;
    assign cmd       = cmd_t'(s_tuser);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign rng_next  = xorshift(seed_reg);
    assign sine_next = sine_reg - (mul_product + dither_reg);

    assign mul_start = (s_accept && cmd == CMD_STEP)
                       || (state_reg == ST_MUL_X && mul_stat.done);
    assign mul_operand = (state_reg == ST_IDLE) ? cosine_reg : sine_next;

    dqo_mul u_mul (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (mul_start),
        .multiplicand (mul_operand),
        .multiplier   (phase_step_reg),
        .stat         (mul_stat),
        .product      (mul_product)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_step_reg  <= PHASE_RESET;
            dither_mask_reg <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                REG_PHASE_STEP:  phase_step_reg  <= cfg_data[PHASE_W-1:0];
                REG_DITHER_MASK: dither_mask_reg <= cfg_data[MASK_W-1:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            sine_reg       <= '0;
            cosine_reg     <= COS_ONE;
            seed_reg       <= SEED_RESET;
            prior_sign_reg <= 1'b0;
            step_cnt_reg   <= '0;
            cross_cnt_reg  <= '0;
            dither_reg     <= '0;
            m_tvalid_reg   <= 1'b0;
            m_tdata_reg    <= '0;
        end
        else
        begin
            // in ST_OUT the output register is reloaded below instead
            if (m_tvalid_reg && m_tready && state_reg != ST_OUT)
            begin
                m_tvalid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    if (s_accept)
                    begin
                        case (cmd)
                            CMD_STEP:
                            begin
                                seed_reg   <= rng_next;
                                // centred dither, wraps at 32 bits
                                dither_reg <= (rng_next & DATA_W'(dither_mask_reg))
                                              - DATA_W'(dither_mask_reg >> 1);
                                state_reg  <= ST_MUL_X;
                            end
                            CMD_RESTART:
                            begin
                                sine_reg       <= '0;
                                cosine_reg     <= COS_ONE;
                                prior_sign_reg <= 1'b0;
                                step_cnt_reg   <= '0;
                                cross_cnt_reg  <= '0;
                                state_reg      <= ST_OUT;
                            end
                            CMD_CLEAR:
                            begin
                                step_cnt_reg  <= '0;
                                cross_cnt_reg <= '0;
                                state_reg     <= ST_OUT;
                            end
                            CMD_LOAD:
                            begin
                                cosine_reg <= s_tdata;
                                state_reg  <= ST_OUT;
                            end
                            default:
                            begin
                                state_reg <= ST_OUT;
                            end
                        endcase
                    end
                end
                ST_MUL_X:
                begin
                    if (mul_stat.done)
                    begin
                        sine_reg       <= sine_next;
                        prior_sign_reg <= sine_next[DATA_W-1];
                        cross_cnt_reg  <= cross_cnt_reg
                                          + DATA_W'(sine_next[DATA_W-1] ^ prior_sign_reg);
                        step_cnt_reg   <= step_cnt_reg + DATA_W'(1);
                        state_reg      <= ST_MUL_Y;
                    end
                end
                ST_MUL_Y:
                begin
                    if (mul_stat.done)
                    begin
                        cosine_reg <= cosine_reg + mul_product;
                        state_reg  <= ST_OUT;
                    end
                end
                ST_OUT:
                begin
                    if (out_free)
                    begin
                        m_tvalid_reg <= 1'b1;
                        m_tdata_reg  <= {cross_cnt_reg, step_cnt_reg, cosine_reg, sine_reg};
                        state_reg    <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

>>> rtl/core/dqo_checker.sv
// port-level checks for the dithered quadrature oscillator, bound to the top level
module dqo_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic [4*dqo_pkg::DATA_W-1:0]  m_tdata
);
    import dqo_pkg::*;

    // a waiting result holds until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed or dropped while stalled");

    // one item in work at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input ready right after an accepted item");

    // a fresh result only ever comes out of a busy cycle
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(!s_tready))
        else $error("result item appeared without work in progress");

endmodule

bind dithered_quadrature_oscillator_top dqo_checker u_dqo_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
